// ----- rtl/tcc_pkg.sv -----
`default_nettype none

package tcc_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 256;

  localparam logic [7:0] COL_LIMIT = 8'(MAX_COLUMNS - 1);
  localparam logic [7:0] ROW_LIMIT = 8'(MAX_ROWS - 1);

  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_BS  = 8'd8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_LEFT   = 3'd1,
    REG_TOP    = 3'd2,
    REG_RIGHT  = 3'd3,
    REG_BOTTOM = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_CLEAR = 2'd2
  } cell_act_t;

  typedef struct packed {
    logic       enable;
    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] bottom;
  } window_t;

  typedef struct packed {
    logic [7:0] cursor_row;
    logic [7:0] cursor_column;
    logic       scroll_request;
    logic [7:0] glyph_code;
    logic [7:0] cell_row;
    logic [7:0] cell_column;
    cell_act_t  cell_action;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

  function automatic logic [7:0] sat_col(input logic [7:0] v);
    return (v > COL_LIMIT) ? COL_LIMIT : v;
  endfunction

  function automatic logic [7:0] sat_row(input logic [7:0] v);
    return (v > ROW_LIMIT) ? ROW_LIMIT : v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/text_console_cursor_control.sv -----
`default_nettype none

// Text console cursor controller. Each character byte on the slave stream
// yields exactly one command on the master stream: a cell action (none, draw
// glyph, clear cell) at a given column and row, a scroll request, and the
// cursor position after the character. Tab, return, line feed and backspace
// move the cursor; other bytes draw and advance, wrapping at the right edge
// and scrolling at the bottom edge of the window. One item per clock is taken
// unless the output stalls; bytes pass the input, then the result register.
// User must write window/enable registers via cfg port only while idle; unchecked.

module text_console_cursor_control (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [tcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [tcc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                s_tvalid,
  output      logic                                s_tready,
  input  wire logic [7:0]                          s_tdata,  // char_code
  output      logic                                m_tvalid,
  input  wire logic                                m_tready,
  // cell_action[1:0], cell_column, cell_row, glyph_code, scroll_request,
  // cursor_column, cursor_row, zero fill
  output      logic [tcc_pkg::OUT_DATA_W-1:0]      m_tdata
);

  tcc_pkg::window_t win;
  logic             in_valid;
  logic [7:0]       in_char;
  logic [7:0]       cursor_col;
  logic [7:0]       cursor_line;
  logic             advance;
  tcc_pkg::result_t step_result;
  tcc_pkg::result_t out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.enable <= 1'b0;
      win.left   <= 8'd0;
      win.right  <= 8'd79;
      win.bottom <= 8'd24;
    end else if (cfg_we) begin
      case (cfg_index)
        tcc_pkg::REG_ENABLE: win.enable <= cfg_data[0];
        tcc_pkg::REG_LEFT:   win.left   <= cfg_data;
        tcc_pkg::REG_RIGHT:  win.right  <= cfg_data;
        tcc_pkg::REG_BOTTOM: win.bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
    end
  end

  tcc_step u_step (
    .char_code (in_char),
    .cur_col   (cursor_col),
    .cur_row   (cursor_line),
    .win       (win),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      cursor_col  <= 8'd0;
      cursor_line <= 8'd0;
    end else begin
      if (advance) begin
        m_tvalid    <= 1'b1;
        cursor_col  <= step_result.cursor_column;
        cursor_line <= step_result.cursor_row;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {{(tcc_pkg::OUT_DATA_W - tcc_pkg::RESULT_W){1'b0}}, out_result};

  ap_cursor_tracks_output: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_result.cursor_column == cursor_col &&
                  out_result.cursor_row == cursor_line))
    else $error("cursor state differs from last result");

  ap_none_is_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_result.cell_action == tcc_pkg::ACT_NONE) |->
      (out_result.cell_column == 8'd0 && out_result.cell_row == 8'd0 &&
       out_result.glyph_code == 8'd0))
    else $error("no-action result carries cell data");

  ap_clear_no_glyph: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_result.cell_action == tcc_pkg::ACT_CLEAR) |->
      out_result.glyph_code == 8'd0)
    else $error("clear result carries a glyph");

  ap_scroll_pins_bottom: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_result.scroll_request) |->
      out_result.cursor_row == tcc_pkg::sat_row(win.bottom))
    else $error("scroll without pinning to bottom row");

  ap_draw_not_control: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_result.cell_action == tcc_pkg::ACT_DRAW) |->
      (out_result.glyph_code != tcc_pkg::CH_TAB && out_result.glyph_code != tcc_pkg::CH_CR &&
       out_result.glyph_code != tcc_pkg::CH_LF && out_result.glyph_code != tcc_pkg::CH_BS))
    else $error("control byte drawn as glyph");

endmodule

`default_nettype wire

// ----- rtl/tcc_step.sv -----
`default_nettype none

module tcc_step (
  input  wire logic              [7:0] char_code,
  input  wire logic              [7:0] cur_col,
  input  wire logic              [7:0] cur_row,
  input  wire tcc_pkg::window_t        win,
  output tcc_pkg::result_t             result
);

  logic [7:0] x1;
  logic [7:0] x2;
  logic [7:0] y2;
  logic [8:0] x;
  logic [9:0] y;
  logic [7:0] x_wrap;
  logic [9:0] y_wrap;
  logic [7:0] x_out;
  logic [7:0] y_out;
  logic       scroll;

  assign x1 = tcc_pkg::sat_col(win.left);
  assign x2 = tcc_pkg::sat_col(win.right);
  assign y2 = tcc_pkg::sat_row(win.bottom);

  always_comb begin
    result = '0;
    x = {1'b0, cur_col};
    y = {2'b00, cur_row};
    case (char_code)
      tcc_pkg::CH_TAB: begin
        x = (x + 9'd8) & ~9'd7;
      end
      tcc_pkg::CH_CR: begin
        x = {1'b0, x1};
      end
      tcc_pkg::CH_LF: begin
        y = y + 10'd1;
        x = {1'b0, x1};
      end
      tcc_pkg::CH_BS: begin
        if (cur_col > x1) begin
          x = x - 9'd1;
          result.cell_action = tcc_pkg::ACT_CLEAR;
          result.cell_column = x[7:0];
          result.cell_row = cur_row;
        end
      end
      default: begin
        result.cell_action = tcc_pkg::ACT_DRAW;
        result.cell_column = cur_col;
        result.cell_row = cur_row;
        result.glyph_code = char_code;
        x = x + 9'd1;
      end
    endcase

    if (x > {1'b0, x2}) begin
      x_wrap = x1;
      y_wrap = y + 10'd1;
    end else begin
      x_wrap = x[7:0];
      y_wrap = y;
    end

    scroll = y_wrap > {2'b00, y2};
    x_out = x_wrap;
    y_out = scroll ? y2 : y_wrap[7:0];

    if (!win.enable) begin
      result = '0;
      result.cursor_column = cur_col;
      result.cursor_row = cur_row;
    end else begin
      result.scroll_request = scroll;
      result.cursor_column = x_out;
      result.cursor_row = y_out;
    end
  end

endmodule

`default_nettype wire
